@@ hw/rtl/pdc_pkg.sv @@
// Shared types, widths and codes of the pivot distance compare block.
package pdc_pkg;

  localparam int ELEM_W               = 16;
  localparam int ELEM_MAX_W           = 24;
  localparam int ELEMENT_BITS_DEFAULT = 16;
  localparam int ACC_W                = 36;
  localparam int ROOT_W               = ACC_W / 2;
  localparam int DIST_W               = 20;
  localparam int METRIC_W             = 2;

  typedef enum logic [METRIC_W-1:0] {
    METRIC_EUCLIDEAN = 2'd0,
    METRIC_MANHATTAN = 2'd1,
    METRIC_CHEBYSHEV = 2'd2
  } metric_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQRT_LOAD,
    ST_SQRT_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] query_elem;
    logic signed [ELEM_W-1:0] first_pivot_elem;
    logic signed [ELEM_W-1:0] second_pivot_elem;
    logic                     last_elem;
  } in_payload_t;

  typedef struct packed {
    logic [DIST_W-1:0] first_distance;
    logic [DIST_W-1:0] second_distance;
    logic              closer_first;
  } out_payload_t;

  typedef struct packed {
    logic take_in;
    logic mul;
    logic acc;
    logic root_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic euclid;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/pdc_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transfer.
interface pdc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/pivot_distance_compare.sv @@
// Top level of the pivot distance compare block.
// Each input transfer carries one coordinate of a query point and of two
// pivot points; the block accumulates both query-to-pivot distances under
// the metric register (0 Euclidean, 1 Manhattan, 2 Chebyshev, 3 acts as
// Chebyshev) and, on the coordinate marked last, emits one result transfer
// with both distances and a flag that is set only when the first distance
// is strictly smaller. The absolute differences are registered at the
// transfer itself; a coordinate then passes the square and then the
// accumulate state, and a new coordinate can be taken in the accumulate
// state unless the current one is last. The last coordinate then goes to the
// finish state for Manhattan and Chebyshev, or for Euclidean first through
// the root load and root run states of the digit-serial square root, which
// resolves two radicand bits per cycle over the 36-bit sum of squares. The
// result sits in an output register, so the next vector can start while a
// finished result waits to be taken; only a second finished result waits for
// that register to drain. Coordinates are read as ELEMENT_BITS-bit two's
// complement values from the low bits of each field. Accumulators saturate at
// 2^36 - 1 and distances at 2^20 - 1. The user must write the metric register
// only while the block is idle; the block itself does not enforce this.
module pivot_distance_compare #(
  parameter int ELEMENT_BITS = pdc_pkg::ELEMENT_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pdc_pkg::METRIC_W-1:0] cfg_data_i,
  pdc_stream_if.sink                   in_i,
  pdc_stream_if.source                 out_o
);
  import pdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller owns input readiness; the datapath owns the result register.
  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pdc_datapath #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_payload_i  (in_i.payload),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_payload_o (out_o.payload)
  );

endmodule

@@ hw/rtl/pdc_isqrt.sv @@
// Digit-by-digit floor square root, two radicand bits per cycle.
module pdc_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pdc_pkg::ACC_W-1:0]  value_i,
  output logic [pdc_pkg::ROOT_W-1:0] root_o,
  output logic                       done_o
);
  import pdc_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic [ACC_W-1:0]  val_q, val_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W-1:0]  rem_s;
  logic [REM_W-1:0]  trial;

  assign rem_s = {rem_q[REM_W-3:0], val_q[ACC_W-1 -: 2]};
  assign trial = REM_W'({root_q, 2'b01});

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      val_d = {val_q[ACC_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (rem_s >= trial) begin
        rem_d  = rem_s - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_s;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

@@ hw/rtl/pdc_datapath.sv @@
// Difference, square, accumulate and result registers of the distance block.
module pdc_datapath #(
  parameter int ELEMENT_BITS = pdc_pkg::ELEMENT_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdc_pkg::cmd_t                 cmd_i,
  output pdc_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic [pdc_pkg::METRIC_W-1:0]  cfg_data_i,
  input  pdc_pkg::in_payload_t          in_payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pdc_pkg::out_payload_t         out_payload_o
);
  import pdc_pkg::*;

  localparam int SQ_W   = 2 * ELEMENT_BITS;
  localparam int WIDE_W = SQ_W + ACC_W;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  function automatic logic [ELEMENT_BITS-1:0] abs_diff(input logic [ELEM_W-1:0] a,
                                                       input logic [ELEM_W-1:0] b);
    logic [ELEM_MAX_W-1:0]          wa;
    logic [ELEM_MAX_W-1:0]          wb;
    logic signed [ELEMENT_BITS:0]   sa;
    logic signed [ELEMENT_BITS:0]   sb;
    logic signed [ELEMENT_BITS:0]   df;
    wa = ELEM_MAX_W'(a);
    wb = ELEM_MAX_W'(b);
    sa = $signed({wa[ELEMENT_BITS-1], wa[ELEMENT_BITS-1:0]});
    sb = $signed({wb[ELEMENT_BITS-1], wb[ELEMENT_BITS-1:0]});
    df = sa - sb;
    if (df[ELEMENT_BITS]) begin
      return ELEMENT_BITS'(-df);
    end
    return df[ELEMENT_BITS-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_square(input logic [ELEMENT_BITS-1:0] d);
    logic [SQ_W-1:0]   sq;
    logic [WIDE_W-1:0] wide;
    sq   = SQ_W'(d) * SQ_W'(d);
    wide = WIDE_W'(sq);
    if (|wide[WIDE_W-1:ACC_W]) begin
      return ACC_MAX;
    end
    return wide[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] accumulate(input logic [METRIC_W-1:0] m,
                                                  input logic [ACC_W-1:0] acc,
                                                  input logic [ACC_W-1:0] term);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + {1'b0, term};
    if (m == METRIC_EUCLIDEAN || m == METRIC_MANHATTAN) begin
      return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    end
    return (term > acc) ? term : acc;
  endfunction

  function automatic logic [DIST_W-1:0] finish(input logic euclid,
                                               input logic [ROOT_W-1:0] root,
                                               input logic [ACC_W-1:0] acc);
    if (euclid) begin
      return DIST_W'(root);
    end
    if (|acc[ACC_W-1:DIST_W]) begin
      return {DIST_W{1'b1}};
    end
    return acc[DIST_W-1:0];
  endfunction

  logic [METRIC_W-1:0]     metric_q;
  logic [ELEMENT_BITS-1:0] d1_q, d2_q;
  logic                    last_q;
  logic [ACC_W-1:0]        term1_q, term2_q;
  logic [ACC_W-1:0]        acc1_q, acc2_q;
  logic                    out_valid_q;
  out_payload_t            out_q;
  logic [ROOT_W-1:0]       root1, root2;
  logic                    root1_done, root2_done;
  logic                    euclid;
  logic [DIST_W-1:0]       dist1, dist2;

  assign euclid = (metric_q == METRIC_EUCLIDEAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_EUCLIDEAN;
    end else if (cfg_we_i) begin
      metric_q <= cfg_data_i;
    end
  end

  // Element stage: absolute differences are taken straight off the transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      d1_q   <= abs_diff(in_payload_i.query_elem, in_payload_i.first_pivot_elem);
      d2_q   <= abs_diff(in_payload_i.query_elem, in_payload_i.second_pivot_elem);
      last_q <= in_payload_i.last_elem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      term1_q <= euclid ? sat_square(d1_q) : ACC_W'(d1_q);
      term2_q <= euclid ? sat_square(d2_q) : ACC_W'(d2_q);
    end
  end

  // Accumulators return to zero after every result, so a new vector starts clean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (cmd_i.load_out) begin
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (cmd_i.acc) begin
      acc1_q <= accumulate(metric_q, acc1_q, term1_q);
      acc2_q <= accumulate(metric_q, acc2_q, term2_q);
    end
  end

  pdc_isqrt u_isqrt_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .value_i (acc1_q),
    .root_o  (root1),
    .done_o  (root1_done)
  );

  pdc_isqrt u_isqrt_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .value_i (acc2_q),
    .root_o  (root2),
    .done_o  (root2_done)
  );

  assign dist1 = finish(euclid, root1, acc1_q);
  assign dist2 = finish(euclid, root2, acc2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.first_distance  <= dist1;
      out_q.second_distance <= dist2;
      out_q.closer_first    <= (dist1 < dist2);
    end
  end

  assign status_o.last      = last_q;
  assign status_o.euclid    = euclid;
  assign status_o.root_done = root1_done & root2_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

endmodule

@@ hw/rtl/pdc_ctrl.sv @@
// Controller state machine sequencing element, root and result steps.
module pdc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdc_pkg::status_t status_i,
  output pdc_pkg::cmd_t    cmd_o
);
  import pdc_pkg::*;

  state_e state_q, state_d;
  logic   ready;
  logic   take;

  assign ready = (state_q == ST_IDLE) || (state_q == ST_ACC && !status_i.last);
  assign take  = in_valid_i && ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (status_i.last) begin
          state_d = status_i.euclid ? ST_SQRT_LOAD : ST_FINISH;
        end else begin
          state_d = take ? ST_MUL : ST_IDLE;
        end
      end
      ST_SQRT_LOAD: begin
        state_d = ST_SQRT_RUN;
      end
      ST_SQRT_RUN: begin
        if (status_i.root_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.take_in    = take;
    cmd_o.mul        = (state_q == ST_MUL);
    cmd_o.acc        = (state_q == ST_ACC);
    cmd_o.root_start = (state_q == ST_SQRT_LOAD);
    cmd_o.load_out   = (state_q == ST_FINISH) && status_i.out_free;
  end

  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_take_only_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_in |-> (state_q == ST_IDLE || (state_q == ST_ACC && !status_i.last)))
    else $error("element taken while the controller is busy");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded over an untaken result");

  a_root_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.root_start |=> (state_q == ST_SQRT_RUN && !status_i.root_done))
    else $error("square root start not followed by a running root");

endmodule
